// ===== rtl/core/sxf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sxf_pkg;

    localparam logic [7:0] SX_START    = 8'hF0;
    localparam logic [7:0] SX_END      = 8'hF7;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [6:0] MAKER_RESET = 7'h7D;

    localparam int GROUP_SIZE = 7;
    localparam int GRP_CNT_W  = 3;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register word index on the config port
    typedef enum logic [0:0] {
        REG_MAKER_ID = 1'b0
    } reg_index_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_payload;
        logic       frame_start;
        logic       frame_last;
        logic [7:0] reply_op;
        logic [7:0] seq_number;
    } in_item_t;

    // one byte through crc8, msb first, no reflection
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sxf_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sxf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       has_payload;
    logic       frame_start;
    logic       frame_last;
    logic [7:0] reply_op;
    logic [7:0] seq_number;

    modport source (
        output valid, payload_byte, has_payload, frame_start, frame_last, reply_op, seq_number,
        input  ready
    );

    modport sink (
        input  valid, payload_byte, has_payload, frame_start, frame_last, reply_op, seq_number,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/sxf_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface sxf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] wire_byte;
    logic       run_end;
    logic       frame_done;

    modport source (
        output valid, wire_byte, run_end, frame_done,
        input  ready
    );

    modport sink (
        input  valid, wire_byte, run_end, frame_done,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/sxf_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sxf_cfg_regs
    import sxf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [6:0]            maker_id
);

    logic [6:0] maker_reg;
    logic       wr_en;
    reg_index_t reg_sel;

    assign pready   = 1'b1;
    assign reg_sel  = reg_index_t'(paddr[2]);
    assign wr_en    = psel && penable && pwrite && pready;
    assign maker_id = maker_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maker_reg <= MAKER_RESET;
        end
        else if (wr_en && (reg_sel == REG_MAKER_ID))
        begin
            maker_reg <= pwdata[6:0];
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_MAKER_ID: prdata = {{(APB_DATA_W-7){1'b0}}, maker_reg};
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/sxf_in_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sxf_in_stage
    import sxf_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sxf_in_if.sink     in_ch,
    input  wire logic  pop,
    output in_item_t   item,
    output logic       item_valid
);

    in_item_t item_reg;
    logic     valid_reg;
    logic     take;

    // refill in the same cycle the held item retires
    assign in_ch.ready = !valid_reg || pop;
    assign take        = in_ch.valid && in_ch.ready;
    assign item        = item_reg;
    assign item_valid  = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.payload_byte <= in_ch.payload_byte;
            item_reg.has_payload  <= in_ch.has_payload;
            item_reg.frame_start  <= in_ch.frame_start;
            item_reg.frame_last   <= in_ch.frame_last;
            item_reg.reply_op     <= in_ch.reply_op;
            item_reg.seq_number   <= in_ch.seq_number;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sxf_emitter.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sxf_emitter
    import sxf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [6:0] maker_id,
    input  in_item_t        item,
    input  wire logic       item_valid,
    output logic            pop,
    sxf_out_if.source       out_ch
);

    typedef enum logic [2:0] {
        PH_BEGIN,
        PH_HEAD,
        PH_PAY,
        PH_FLUSH,
        PH_CRC,
        PH_END
    } phase_t;

    localparam logic [2:0] HDR_START = 3'd0;
    localparam logic [2:0] HDR_MAKER = 3'd1;
    localparam logic [2:0] HDR_OP    = 3'd2;
    localparam logic [2:0] HDR_SEQ   = 3'd3;

    phase_t               phase_reg, phase_next, cur_phase;
    logic [2:0]           idx_reg, idx_next;
    logic [GRP_CNT_W-1:0] cnt_reg, cnt_next, cnt_fill;
    logic [7:0]           crc_reg, crc_next;
    logic [7:0]           group_reg [GROUP_SIZE];
    logic [2:0]           grp_sel;
    logic [6:0]           mask;
    logic                 grp_we;
    logic                 slot_free;
    logic                 emit;
    logic                 finish;
    logic [7:0]           beat_byte;
    logic                 beat_end;
    logic                 beat_done;

    logic                 out_valid_reg;
    logic [7:0]           out_byte_reg;
    logic                 out_end_reg;
    logic                 out_done_reg;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign cur_phase = (phase_reg == PH_BEGIN) ?
                       (item.frame_start ? PH_HEAD : PH_PAY) : phase_reg;
    assign grp_sel   = idx_reg - 3'd1;
    assign cnt_fill  = item.has_payload ? (cnt_reg + GRP_CNT_W'(1)) : cnt_reg;
    assign pop       = finish;

    always_comb
    begin
        for (int i = 0; i < GROUP_SIZE; i++)
        begin
            mask[i] = group_reg[i][7] && (GRP_CNT_W'(i) < cnt_reg);
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        crc_next   = crc_reg;
        grp_we     = 1'b0;
        emit       = 1'b0;
        finish     = 1'b0;
        beat_byte  = 8'h00;
        beat_end   = 1'b0;
        beat_done  = 1'b0;

        if (item_valid)
        begin
            case (cur_phase)
                PH_HEAD:
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_HEAD;
                        idx_next   = idx_reg + 3'd1;
                        case (idx_reg)
                            HDR_START:
                            begin
                                beat_byte = SX_START;
                                cnt_next  = '0;
                                crc_next  = 8'h00;
                            end
                            HDR_MAKER:
                            begin
                                beat_byte = {1'b0, maker_id};
                            end
                            HDR_OP:
                            begin
                                beat_byte = item.reply_op;
                                crc_next  = crc8_step(crc_reg, item.reply_op);
                            end
                            HDR_SEQ:
                            begin
                                beat_byte  = item.seq_number;
                                crc_next   = crc8_step(crc_reg, item.seq_number);
                                // a lone payload byte after a header never fills a group
                                beat_end   = !item.frame_last;
                                phase_next = PH_PAY;
                                idx_next   = 3'd0;
                            end
                            default:
                            begin
                                phase_next = PH_PAY;
                                idx_next   = 3'd0;
                            end
                        endcase
                    end
                end
                PH_PAY:
                begin
                    grp_we   = item.has_payload;
                    cnt_next = cnt_fill;
                    idx_next = 3'd0;
                    if (item.has_payload && (cnt_fill == GRP_CNT_W'(GROUP_SIZE)))
                    begin
                        phase_next = PH_FLUSH;
                    end
                    else if (item.frame_last)
                    begin
                        phase_next = (cnt_fill != '0) ? PH_FLUSH : PH_CRC;
                    end
                    else
                    begin
                        finish     = 1'b1;
                        phase_next = PH_BEGIN;
                    end
                end
                PH_FLUSH:
                begin
                    if (slot_free)
                    begin
                        emit = 1'b1;
                        if (idx_reg == 3'd0)
                        begin
                            beat_byte = {1'b0, mask};
                        end
                        else
                        begin
                            beat_byte = {1'b0, group_reg[grp_sel][6:0]};
                        end
                        crc_next = crc8_step(crc_reg, beat_byte);
                        if (idx_reg == cnt_reg)
                        begin
                            cnt_next = '0;
                            idx_next = 3'd0;
                            beat_end = !item.frame_last;
                            if (item.frame_last)
                            begin
                                phase_next = PH_CRC;
                            end
                            else
                            begin
                                finish     = 1'b1;
                                phase_next = PH_BEGIN;
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + 3'd1;
                        end
                    end
                end
                PH_CRC:
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        beat_byte  = {1'b0, crc_reg[6:0]};
                        phase_next = PH_END;
                    end
                end
                PH_END:
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        beat_byte  = SX_END;
                        beat_end   = 1'b1;
                        beat_done  = 1'b1;
                        cnt_next   = '0;
                        crc_next   = 8'h00;
                        finish     = 1'b1;
                        phase_next = PH_BEGIN;
                        idx_next   = 3'd0;
                    end
                end
                default:
                begin
                    phase_next = PH_BEGIN;
                    idx_next   = 3'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BEGIN;
            idx_reg       <= 3'd0;
            cnt_reg       <= '0;
            crc_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'h00;
            out_end_reg   <= 1'b0;
            out_done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= beat_byte;
                out_end_reg   <= beat_end;
                out_done_reg  <= beat_done;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_we)
        begin
            group_reg[cnt_reg] <= item.payload_byte;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.wire_byte  = out_byte_reg;
    assign out_ch.run_end    = out_end_reg;
    assign out_ch.frame_done = out_done_reg;

`ifndef NO_ASSERTIONS
    a_full_group_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == GRP_CNT_W'(GROUP_SIZE)) |-> (phase_reg == PH_FLUSH))
        else $error("full group held outside flush");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && emit && (cur_phase == PH_END)) |=> ((crc_reg == 8'h00) && (cnt_reg == '0)))
        else $error("crc or group count not cleared after frame close");

    a_done_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |-> (out_end_reg && (out_byte_reg == SX_END)))
        else $error("frame close beat malformed");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> item_valid)
        else $error("retired an item that was not held");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sysex_reply_framer.sv =====
// an accepted item is held in the input stage register and each beat in the output
//   beat register; the next item is taken as the held one retires
// a frame start adds four header beats, a full group a mask and seven data beats,
//   a frame close a crc and an end beat, a short group at close its size plus 1
// reset: rst_n async active low clears the sequencer, crc, group count and beat
//   register and sets maker_id to 0x7d; the group buffer is left as is
`timescale 1ns / 1ps
`default_nettype none

module sysex_reply_framer
    import sxf_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sxf_in_if.sink                     in_ch,
    sxf_out_if.source                  out_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic [6:0] maker_id;
    in_item_t   item;
    logic       item_valid;
    logic       pop;

    sxf_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .maker_id (maker_id)
    );

    sxf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .pop        (pop),
        .item       (item),
        .item_valid (item_valid)
    );

    sxf_emitter u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .maker_id   (maker_id),
        .item       (item),
        .item_valid (item_valid),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// ===== tb/sv/sysex_reply_framer_test.sv =====
`timescale 1ns / 1ps

module sysex_reply_framer_test;

    import sxf_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 12;
    localparam int PHASE_ITEMS   = 60;
    localparam logic [APB_ADDR_W-1:0] MAKER_ADDR = APB_ADDR_W'(4 * int'(REG_MAKER_ID));

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       run_end;
        logic       frame_done;
    } wire_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sxf_in_if  in_ch ();
    sxf_out_if out_ch ();

    sysex_reply_framer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the framer state
    logic [7:0] grp_buf [GROUP_SIZE];
    int         grp_cnt;
    logic [7:0] crc_acc;
    logic [6:0] maker_shadow;
    wire_beat_t frame_pending [$];
    wire_beat_t wire_expected [$];
    wire_beat_t exp_beat;

    int idle_pct;
    int stall_pct;
    int hold_ask;
    int hold_left;
    int err_count;
    int in_beats;
    int in_counted;
    int out_beats;
    int frames_closed;
    int quiet_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void note_fail(input string msg);
        err_count++;
        if (err_count <= 10)
        begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic logic [7:0] crc_update(input logic [7:0] acc, input logic [7:0] din);
        logic [7:0] r;
        r = acc ^ din;
        repeat (8)
        begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic void put_beat(input logic [7:0] b, input logic done, input logic in_crc);
        if (in_crc)
        begin
            crc_acc = crc_update(crc_acc, b);
        end
        frame_pending.push_back('{wire_byte: b, run_end: 1'b0, frame_done: done});
    endfunction

    // mask byte carries bit 7 of each buffered byte, then the low seven bits follow
    function automatic void flush_group_beats();
        logic [7:0] mask;
        mask = '0;
        for (int i = 0; i < grp_cnt; i++)
        begin
            mask[i] = grp_buf[i][7];
        end
        put_beat(mask, 1'b0, 1'b1);
        for (int i = 0; i < grp_cnt; i++)
        begin
            put_beat({1'b0, grp_buf[i][6:0]}, 1'b0, 1'b1);
        end
        grp_cnt = 0;
    endfunction

    function automatic void frame_predict(input in_item_t it);
        frame_pending.delete();
        if (it.frame_start)
        begin
            grp_cnt = 0;
            crc_acc = '0;
            put_beat(SX_START, 1'b0, 1'b0);
            put_beat({1'b0, maker_shadow}, 1'b0, 1'b0);
            put_beat(it.reply_op, 1'b0, 1'b1);
            put_beat(it.seq_number, 1'b0, 1'b1);
        end
        if (it.has_payload)
        begin
            if (grp_cnt >= GROUP_SIZE)
            begin
                grp_cnt = 0;
            end
            grp_buf[grp_cnt] = it.payload_byte;
            grp_cnt++;
            if (grp_cnt == GROUP_SIZE)
            begin
                flush_group_beats();
            end
        end
        if (it.frame_last)
        begin
            if (grp_cnt > 0)
            begin
                flush_group_beats();
            end
            put_beat({1'b0, crc_acc[6:0]}, 1'b0, 1'b0);
            put_beat(SX_END, 1'b1, 1'b0);
            grp_cnt = 0;
            crc_acc = '0;
        end
        if (frame_pending.size() > 0)
        begin
            frame_pending[frame_pending.size() - 1].run_end = 1'b1;
            foreach (frame_pending[i])
            begin
                wire_expected.push_back(frame_pending[i]);
            end
        end
    endfunction

    function automatic in_item_t make_item(input logic [7:0] pb, input bit has, input bit st,
                                           input bit la);
        in_item_t it;
        it.payload_byte = pb;
        it.has_payload  = has;
        it.frame_start  = st;
        it.frame_last   = la;
        it.reply_op     = 8'($urandom);
        it.seq_number   = 8'($urandom);
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.payload_byte <= it.payload_byte;
        in_ch.has_payload  <= it.has_payload;
        in_ch.frame_start  <= it.frame_start;
        in_ch.frame_last   <= it.frame_last;
        in_ch.reply_op     <= it.reply_op;
        in_ch.seq_number   <= it.seq_number;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        in_beats++;
        if (it.has_payload || it.frame_start || it.frame_last)
        begin
            in_counted++;
        end
        frame_predict(it);
    endtask

    // stop offering, drain all expected beats, then give zero-result items time to retire
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (wire_expected.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_xfer(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic verify_maker();
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b0, MAKER_ADDR, '0, rd);
        if (rd[6:0] !== maker_shadow)
        begin
            note_fail($sformatf("maker_id readback expected %02h actual %02h",
                                maker_shadow, rd[6:0]));
        end
    endtask

    task automatic set_maker(input logic [APB_DATA_W-1:0] v);
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b1, MAKER_ADDR, v, rd);
        maker_shadow = v[6:0];
        verify_maker();
    endtask

    task automatic send_random_frame();
        int       n;
        bit       lead_empty;
        bit       tail_empty;
        in_item_t it;
        n = ($urandom_range(7) == 0) ? $urandom_range(16, 30) : $urandom_range(0, 15);
        if (n == 0)
        begin
            if ($urandom_range(1) == 0)
            begin
                send_item(make_item(8'($urandom), 1'b0, 1'b1, 1'b1));
            end
            else
            begin
                send_item(make_item(8'($urandom), 1'b0, 1'b1, 1'b0));
                send_item(make_item(8'($urandom), 1'b0, 1'b0, 1'b1));
            end
        end
        else
        begin
            lead_empty = ($urandom_range(3) == 0);
            tail_empty = ($urandom_range(3) == 0);
            if (lead_empty)
            begin
                send_item(make_item(8'($urandom), 1'b0, 1'b1, 1'b0));
            end
            for (int i = 0; i < n; i++)
            begin
                it = make_item(8'($urandom), 1'b1, (i == 0) && !lead_empty,
                               (i == n - 1) && !tail_empty);
                send_item(it);
            end
            if (tail_empty)
            begin
                send_item(make_item(8'($urandom), 1'b0, 1'b0, 1'b1));
            end
        end
    endtask

    task automatic test_register_access();
        verify_maker();
        set_maker(32'h0000_0000);
    endtask

    task automatic test_empty_frames();
        in_item_t it;
        it = make_item(8'hFF, 1'b0, 1'b1, 1'b1);
        it.reply_op   = 8'h00;
        it.seq_number = 8'h00;
        send_item(it);
        send_item(make_item(8'h00, 1'b0, 1'b1, 1'b0));
        send_item(make_item(8'hFF, 1'b0, 1'b0, 1'b1));
        // close with no frame open
        send_item(make_item(8'h5A, 1'b0, 1'b0, 1'b1));
        settle();
    endtask

    task automatic test_group_boundaries();
        in_item_t it;
        it = make_item(8'hFF, 1'b1, 1'b1, 1'b0);
        it.reply_op   = 8'hFF;
        it.seq_number = 8'hFF;
        send_item(it);
        send_item(make_item(8'h80, 1'b1, 1'b0, 1'b0));
        send_item(make_item(8'h7F, 1'b1, 1'b0, 1'b0));
        send_item(make_item(8'h00, 1'b1, 1'b0, 1'b0));
        send_item(make_item(8'h01, 1'b1, 1'b0, 1'b0));
        send_item(make_item(8'h55, 1'b1, 1'b0, 1'b0));
        // seventh byte fills the group on the closing beat
        send_item(make_item(8'hAA, 1'b1, 1'b0, 1'b1));
        settle();
    endtask

    task automatic test_restart_and_orphans();
        send_item(make_item(8'h00, 1'b0, 1'b1, 1'b0));
        send_item(make_item(8'h81, 1'b1, 1'b0, 1'b0));
        send_item(make_item(8'h02, 1'b1, 1'b0, 1'b0));
        // restart drops the two buffered bytes
        send_item(make_item(8'hC3, 1'b1, 1'b1, 1'b0));
        send_item(make_item(8'h44, 1'b1, 1'b0, 1'b0));
        send_item(make_item(8'h00, 1'b0, 1'b0, 1'b1));
        send_item(make_item(8'hE7, 1'b0, 1'b0, 1'b0));
        // payload with no header in front
        send_item(make_item(8'h9A, 1'b1, 1'b0, 1'b0));
        send_item(make_item(8'h7E, 1'b1, 1'b0, 1'b1));
        settle();
    endtask

    task automatic test_random_traffic();
        int       phase_idle [4];
        int       phase_stall [4];
        int       target;
        int       pick;
        in_item_t it;
        phase_idle  = '{0, 52, 0, 30};
        phase_stall = '{0, 0, 52, 30};
        for (int p = 0; p < 4; p++)
        begin
            settle();
            case (p)
                0: set_maker(32'h0000_007F);
                1: set_maker(32'hFFFF_FF80);
                default: set_maker(32'($urandom_range(1, 126)));
            endcase
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            target    = in_counted + PHASE_ITEMS;
            while (in_counted < target)
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                begin
                    send_random_frame();
                end
                else if (pick < 90)
                begin
                    send_item(make_item(8'($urandom), 1'b0, 1'b0, 1'b0));
                end
                else if (pick < 95)
                begin
                    send_item(make_item(8'($urandom), 1'b1, 1'b0, $urandom_range(3) == 0));
                end
                else
                begin
                    it = make_item(8'($urandom), 1'($urandom_range(1)),
                                   1'($urandom_range(1)), 1'($urandom_range(1)));
                    send_item(it);
                end
            end
        end
        settle();
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_ask = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
        begin
            send_item(make_item(8'($urandom), 1'b1, i == 0, i == 39));
        end
        settle();
    endtask

    // receiver: random stalls plus an optional long hold-off
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ask > 0)
            begin
                hold_left = hold_ask;
                hold_ask  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            out_beats++;
            if (wire_expected.size() == 0)
            begin
                note_fail($sformatf("unexpected beat byte=%02h run_end=%0b frame_done=%0b",
                                    out_ch.wire_byte, out_ch.run_end, out_ch.frame_done));
            end
            else
            begin
                exp_beat = wire_expected.pop_front();
                if (out_ch.wire_byte !== exp_beat.wire_byte
                    || out_ch.run_end !== exp_beat.run_end
                    || out_ch.frame_done !== exp_beat.frame_done)
                begin
                    note_fail($sformatf({"beat %0d expected byte=%02h run_end=%0b ",
                                         "frame_done=%0b actual byte=%02h run_end=%0b ",
                                         "frame_done=%0b"},
                                        out_beats, exp_beat.wire_byte, exp_beat.run_end,
                                        exp_beat.frame_done, out_ch.wire_byte,
                                        out_ch.run_end, out_ch.frame_done));
                end
                if (exp_beat.frame_done)
                begin
                    frames_closed++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[sysex_reply_framer] ERROR");
            $finish;
        end
    end

    initial
    begin
        grp_cnt      = 0;
        crc_acc      = '0;
        maker_shadow = MAKER_RESET;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_ask     = 0;
        hold_left    = 0;
        err_count    = 0;
        in_beats     = 0;
        in_counted   = 0;
        out_beats    = 0;
        frames_closed = 0;
        quiet_cycles = 0;
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.payload_byte <= '0;
        in_ch.has_payload  <= 1'b0;
        in_ch.frame_start  <= 1'b0;
        in_ch.frame_last   <= 1'b0;
        in_ch.reply_op     <= '0;
        in_ch.seq_number   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_empty_frames();
        test_group_boundaries();
        test_restart_and_orphans();
        test_random_traffic();
        test_backpressure();

        $display("covered %0d input beats (%0d doing work) and %0d wire beats in %0d frames",
                 in_beats, in_counted, out_beats, frames_closed);
        $display("directed framing cases, four idle/stall mixes, five maker ids, one hold-off");
        if (err_count == 0)
        begin
            $display("[sysex_reply_framer] OK");
        end
        else
        begin
            $display("%0d failures", err_count);
            $display("[sysex_reply_framer] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/sxf_pkg.sv
rtl/core/sxf_in_if.sv
rtl/core/sxf_out_if.sv
rtl/core/sxf_cfg_regs.sv
rtl/core/sxf_in_stage.sv
rtl/core/sxf_emitter.sv
rtl/core/sysex_reply_framer.sv
tb/sv/sysex_reply_framer_test.sv
